// ===== rtl/lldp_pkg.sv =====
// ----------------------------------------------------------------------------
// lldp_pkg
// Shared constants and types of the least loaded device picker.
// ----------------------------------------------------------------------------
package lldp_pkg;

  localparam int MAX_DEVICES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  // field widths of the transactions
  localparam int DEV_W    = 4;
  localparam int STATUS_W = 2;
  localparam int LOAD_W   = 16;

  // configuration register
  localparam int                ACTIVE_W     = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam int                ADDR_W       = 3;
  localparam int                DATA_W       = 32;
  localparam logic [ADDR_W-1:0] ADDR_ACTIVE  = 3'd0;

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_IDLE_REFUSED  = 2'd1,
    ST_RANGE_REFUSED = 2'd2,
    ST_SATURATED     = 2'd3
  } status_e;

  // counter update broadcast to the cells
  typedef struct packed {
    logic en;
    logic inc;
  } upd_t;

endpackage

// ===== rtl/lldp_cell.sv =====
// ----------------------------------------------------------------------------
// lldp_cell
// One device counter plus one stage of the running minimum scan.
// ----------------------------------------------------------------------------
module lldp_cell #(
  parameter int IDX_W      = 4,
  parameter int COUNT_BITS = lldp_pkg::COUNT_BITS_DEF,
  parameter int CELL_INDEX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cand_valid_i,
  input  logic [IDX_W-1:0]      cand_idx_i,
  input  logic [COUNT_BITS-1:0] cand_val_i,
  input  logic                  clear_i,
  input  lldp_pkg::upd_t        upd_i,
  input  logic [IDX_W-1:0]      upd_idx_i,
  output logic                  cand_valid_o,
  output logic [IDX_W-1:0]      cand_idx_o,
  output logic [COUNT_BITS-1:0] cand_val_o,
  output logic [COUNT_BITS-1:0] count_o
);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  cand_valid_q;
  logic [IDX_W-1:0]      cand_idx_q, cand_idx_d;
  logic [COUNT_BITS-1:0] cand_val_q, cand_val_d;
  logic                  hit;

  assign hit = upd_i.en && (upd_idx_i == IDX_W'(CELL_INDEX));

  always_comb begin
    count_d = count_q;
    if (hit) begin
      count_d = upd_i.inc ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  // strict less keeps the earlier index on a tie
  always_comb begin
    if (count_q < cand_val_i) begin
      cand_idx_d = IDX_W'(CELL_INDEX);
      cand_val_d = count_q;
    end else begin
      cand_idx_d = cand_idx_i;
      cand_val_d = cand_val_i;
    end
  end

  // the scan token dies once the tap has taken it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      cand_valid_q <= 1'b0;
    end else begin
      count_q      <= count_d;
      cand_valid_q <= cand_valid_i && !clear_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_idx_q <= cand_idx_d;
    cand_val_q <= cand_val_d;
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_idx_o   = cand_idx_q;
  assign cand_val_o   = cand_val_q;
  assign count_o      = count_q;

endmodule

// ===== rtl/least_loaded_device_picker_top.sv =====
// ----------------------------------------------------------------------------
// least_loaded_device_picker_top
// Keeps an outstanding job count per device and hands out the least loaded.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries opcode_i and device_index_i.
//   Acquire picks the active device with the smallest count (lowest index on
//   a tie) and increments it; release decrements the named device's count.
//   Output channel (out_valid_o/out_ready_i) returns chosen_device_o,
//   status_o and new_load_o, one result per input transaction.
//   One transaction is in flight at a time. An acquire's result is found by
//   the scan token walking the row of counter cells one cell per cycle up to
//   the last of the n effective active devices. A release's result is one
//   counter read through a mux. The next input is taken once the result has
//   entered the output register.
//   Results sit in an output register; the next input is accepted while a
//   result waits, and a second result waits in the engine until the
//   receiver takes the first one.
//   Reset clears all counts and sets active_devices to 16. The user must write
//   active_devices over APB at address 0 only while idle; not enforced.
// ----------------------------------------------------------------------------
module least_loaded_device_picker_top #(
  parameter int MAX_DEVICES = lldp_pkg::MAX_DEVICES_DEF,
  parameter int COUNT_BITS  = lldp_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lldp_pkg::ADDR_W-1:0]   paddr,
  input  logic [lldp_pkg::DATA_W-1:0]   pwdata,
  output logic [lldp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [lldp_pkg::DEV_W-1:0]    device_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lldp_pkg::DEV_W-1:0]    chosen_device_o,
  output logic [lldp_pkg::STATUS_W-1:0] status_o,
  output logic [lldp_pkg::LOAD_W-1:0]   new_load_o
);

  localparam int IDX_W = $clog2(MAX_DEVICES);
  localparam int LIMIT = (MAX_DEVICES < 16) ? MAX_DEVICES : 16;
  localparam int AW    = lldp_pkg::ACTIVE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e                       state_q;
  logic [AW-1:0]                active_q;
  logic [AW-1:0]                n_eff, n_q;
  logic                         op_q;
  logic [lldp_pkg::DEV_W-1:0]   dev_q;
  logic                         start_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic [COUNT_BITS-1:0]        best_val_q;
  logic                         out_valid_q;
  logic [lldp_pkg::DEV_W-1:0]   chosen_q;
  logic [lldp_pkg::STATUS_W-1:0] status_q;
  logic [lldp_pkg::LOAD_W-1:0]  load_q;

  logic                         cv   [MAX_DEVICES+1];
  logic [IDX_W-1:0]             ci   [MAX_DEVICES+1];
  logic [COUNT_BITS-1:0]        cval [MAX_DEVICES+1];
  logic [COUNT_BITS-1:0]        counts [MAX_DEVICES];

  lldp_pkg::upd_t               upd;
  logic [IDX_W-1:0]             upd_idx;
  logic                         cfg_wr, accept, fire;
  logic                         last_valid;
  logic                         scan_done;
  logic [IDX_W-1:0]             last_idx;
  logic [COUNT_BITS-1:0]        last_val;
  logic [COUNT_BITS-1:0]        rel_cnt;
  logic [lldp_pkg::DEV_W-1:0]   res_chosen;
  lldp_pkg::status_e            res_status;
  logic [COUNT_BITS-1:0]        res_load;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == lldp_pkg::ADDR_ACTIVE);
  assign prdata = (paddr == lldp_pkg::ADDR_ACTIVE)
                  ? lldp_pkg::DATA_W'(active_q) : '0;

  always_comb begin
    n_eff = active_q;
    if (active_q == '0) begin
      n_eff = AW'(1);
    end else if (active_q > AW'(LIMIT)) begin
      n_eff = AW'(LIMIT);
    end
  end

  // cell chain
  assign cv[0]   = start_q;
  assign ci[0]   = '0;
  assign cval[0] = '1;

  for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_cell
    lldp_cell #(
      .IDX_W      (IDX_W),
      .COUNT_BITS (COUNT_BITS),
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cand_valid_i (cv[g]),
      .cand_idx_i   (ci[g]),
      .cand_val_i   (cval[g]),
      .clear_i      (scan_done),
      .upd_i        (upd),
      .upd_idx_i    (upd_idx),
      .cand_valid_o (cv[g+1]),
      .cand_idx_o   (ci[g+1]),
      .cand_val_o   (cval[g+1]),
      .count_o      (counts[g])
    );
  end

  // tap the chain at the last active cell, and read the released counter
  always_comb begin
    last_valid = 1'b0;
    last_idx   = '0;
    last_val   = '0;
    rel_cnt    = '0;
    for (int k = 0; k < LIMIT; k++) begin
      if (n_q == AW'(k + 1)) begin
        last_valid = cv[k+1];
        last_idx   = ci[k+1];
        last_val   = cval[k+1];
      end
      if (dev_q == lldp_pkg::DEV_W'(k)) begin
        rel_cnt = counts[k];
      end
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign fire      = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);
  assign scan_done = (state_q == S_SCAN) && last_valid;

  always_comb begin
    res_chosen = dev_q;
    res_status = lldp_pkg::ST_OK;
    res_load   = '0;
    upd.inc    = 1'b0;
    upd.en     = 1'b0;
    upd_idx    = IDX_W'(dev_q);
    if (op_q == lldp_pkg::OP_ACQUIRE) begin
      res_chosen = lldp_pkg::DEV_W'(best_idx_q);
      upd.inc    = 1'b1;
      upd_idx    = best_idx_q;
      if (best_val_q == '1) begin
        res_status = lldp_pkg::ST_SATURATED;
        res_load   = best_val_q;
      end else begin
        res_load = best_val_q + 1'b1;
        upd.en   = fire;
      end
    end else begin
      if ({1'b0, dev_q} >= n_q) begin
        res_status = lldp_pkg::ST_RANGE_REFUSED;
      end else if (rel_cnt == '0) begin
        res_status = lldp_pkg::ST_IDLE_REFUSED;
      end else begin
        res_load = rel_cnt - 1'b1;
        upd.en   = fire;
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= lldp_pkg::ACTIVE_RESET;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= accept && (opcode_i == lldp_pkg::OP_ACQUIRE);
      if (cfg_wr) begin
        active_q <= pwdata[AW-1:0];
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (opcode_i == lldp_pkg::OP_ACQUIRE) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_RESULT;
            end
          end
        end
        S_SCAN: begin
          if (last_valid) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      dev_q <= device_index_i;
      n_q   <= n_eff;
    end
    if (scan_done) begin
      best_idx_q <= last_idx;
      best_val_q <= last_val;
    end
    if (fire) begin
      chosen_q <= res_chosen;
      status_q <= res_status;
      load_q   <= lldp_pkg::LOAD_W'(res_load);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_device_o = chosen_q;
  assign status_o        = status_q;
  assign new_load_o      = load_q;

endmodule

// ===== rtl/lldp_checker.sv =====
// ----------------------------------------------------------------------------
// lldp_checker
// Port level checks of the least loaded device picker, bound to the top.
// ----------------------------------------------------------------------------
module lldp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [lldp_pkg::DEV_W-1:0]    chosen_device_o,
  input logic [lldp_pkg::STATUS_W-1:0] status_o,
  input logic [lldp_pkg::LOAD_W-1:0]   new_load_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(chosen_device_o)
      && $stable(status_o) && $stable(new_load_o))
    else $error("stalled result changed");

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // refused releases report zero load
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lldp_pkg::ST_IDLE_REFUSED
      || status_o == lldp_pkg::ST_RANGE_REFUSED) |-> new_load_o == '0)
    else $error("refused release with nonzero load");

  // a result never follows its request in the same or next cycle
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind least_loaded_device_picker_top lldp_checker u_lldp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .chosen_device_o (chosen_device_o),
  .status_o        (status_o),
  .new_load_o      (new_load_o)
);

// ===== dv/tb_least_loaded_device_picker_top.sv =====
// ----------------------------------------------------------------------------
// tb_least_loaded_device_picker_top
// Self-checking bench for the least loaded device picker. A clocked driver
// feeds acquire and release transactions from a queue. A scoreboard model of
// the per-device job counts predicts every result at input acceptance, and
// the monitor compares each accepted result against the oldest prediction.
// The run covers directed corner cases and random phases under several device
// counts with random stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_least_loaded_device_picker_top;

  localparam int NUM_DEV     = lldp_pkg::MAX_DEVICES_DEF;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_WAIT  = 40;
  localparam int DEV_W       = lldp_pkg::DEV_W;
  localparam int ACTIVE_W    = lldp_pkg::ACTIVE_W;
  localparam int DATA_W      = lldp_pkg::DATA_W;
  localparam int LOAD_W      = lldp_pkg::LOAD_W;
  localparam logic [lldp_pkg::COUNT_BITS_DEF-1:0] COUNT_FULL = '1;

  typedef struct {
    lldp_pkg::opcode_e op;
    logic [DEV_W-1:0]  dev;
  } job_t;

  typedef struct {
    logic [DEV_W-1:0]  chosen;
    lldp_pkg::status_e status;
    logic [LOAD_W-1:0] load;
  } pick_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lldp_pkg::ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]             pwdata = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_ready_o;
  lldp_pkg::opcode_e             op_drv = lldp_pkg::OP_ACQUIRE;
  logic [DEV_W-1:0]              dev_drv = '0;
  logic                          out_valid_o;
  logic                          out_ready = 1'b0;
  logic [DEV_W-1:0]              chosen_device_o;
  logic [lldp_pkg::STATUS_W-1:0] status_o;
  logic [LOAD_W-1:0]             new_load_o;

  // scoreboard model state
  logic [lldp_pkg::COUNT_BITS_DEF-1:0] job_load [NUM_DEV];
  logic [ACTIVE_W-1:0]                 active_cfg;

  job_t  job_q[$];
  pick_t pick_q[$];
  job_t  cur_job;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_len = 0;
  int cycle_cnt = 0;

  least_loaded_device_picker_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .opcode_i        (op_drv),
    .device_index_i  (dev_drv),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .chosen_device_o (chosen_device_o),
    .status_o        (status_o),
    .new_load_o      (new_load_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL least_loaded_device_picker_top");
    $finish;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // 0 acts as one device, anything above the table size as the whole table
  function automatic int unsigned eff_devices(input logic [ACTIVE_W-1:0] a);
    if (a == 0) return 1;
    if (a > NUM_DEV) return NUM_DEV;
    return a;
  endfunction

  // updates the job counts for one accepted transaction, queues its result
  function automatic void book_job(input job_t j);
    int unsigned n;
    logic [DEV_W-1:0] best;
    pick_t r;
    n = eff_devices(active_cfg);
    best = '0;
    r.status = lldp_pkg::ST_OK;
    if (j.op == lldp_pkg::OP_ACQUIRE) begin
      for (int i = 1; i < n; i++) begin
        if (job_load[i] < job_load[best]) best = DEV_W'(i);
      end
      if (job_load[best] == COUNT_FULL) r.status = lldp_pkg::ST_SATURATED;
      else job_load[best] = job_load[best] + 1'b1;
      r.chosen = best;
      r.load = job_load[best][LOAD_W-1:0];
    end else begin
      r.chosen = j.dev;
      if (j.dev >= n) begin
        r.status = lldp_pkg::ST_RANGE_REFUSED;
        r.load = '0;
      end else if (job_load[j.dev] == 0) begin
        r.status = lldp_pkg::ST_IDLE_REFUSED;
        r.load = '0;
      end else begin
        job_load[j.dev] = job_load[j.dev] - 1'b1;
        r.load = job_load[j.dev][LOAD_W-1:0];
      end
    end
    pick_q.push_back(r);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready_o) book_job(cur_job);
      if (!in_valid || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (job_q.size() != 0 && send_idle_pct != 0 &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 11);
          in_valid <= 1'b0;
        end else if (job_q.size() != 0) begin
          cur_job = job_q.pop_front();
          in_valid <= 1'b1;
          op_drv <= cur_job.op;
          dev_drv <= cur_job.dev;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output-side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    pick_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pick_q.size() == 0) begin
          flag_error($sformatf("unexpected result dev=%0d status=%0d load=%0d",
                               chosen_device_o, status_o, new_load_o));
        end else begin
          e = pick_q.pop_front();
          if (chosen_device_o !== e.chosen || status_o !== e.status ||
              new_load_o !== e.load)
            flag_error($sformatf("exp dev=%0d status=%0d load=%0d, got dev=%0d status=%0d load=%0d",
                                 e.chosen, e.status, e.load,
                                 chosen_device_o, status_o, new_load_o));
        end
      end
      if (hold_len != 0) begin
        hold_len--;
        out_ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_stall = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (job_q.size() != 0 || in_valid || pick_q.size() != 0) @(negedge clk_i);
  endtask

  // write active_devices, then read it back
  task automatic write_active(input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lldp_pkg::ADDR_ACTIVE;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    active_cfg = data[ACTIVE_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== DATA_W'(data[ACTIVE_W-1:0]))
      flag_error($sformatf("active_devices readback exp %0d got %0h",
                           data[ACTIVE_W-1:0], rd));
  endtask

  task automatic push_job(input lldp_pkg::opcode_e op, input logic [DEV_W-1:0] dev);
    job_t j;
    j.op = op;
    j.dev = dev;
    job_q.push_back(j);
  endtask

  // acquires at the given percentage; releases mostly of active devices, some of any device
  function automatic job_t make_job(input int acq_pct);
    job_t j;
    int unsigned n;
    n = eff_devices(active_cfg);
    j.dev = DEV_W'($urandom_range(0, NUM_DEV - 1));
    if ($urandom_range(0, 99) < acq_pct) begin
      j.op = lldp_pkg::OP_ACQUIRE;
    end else begin
      j.op = lldp_pkg::OP_RELEASE;
      if ($urandom_range(0, 99) < 80) j.dev = DEV_W'($urandom_range(0, n - 1));
    end
    return j;
  endfunction

  task automatic run_phase(input logic [ACTIVE_W-1:0] setting, input int count,
                           input int acq_pct, input int s_idle, input int r_idle,
                           input bit long_hold);
    logic [DATA_W-1:0] data;
    wait_idle();
    // random upper bits, the register keeps only its own width
    data = ($urandom() & ~DATA_W'({ACTIVE_W{1'b1}})) | DATA_W'(setting);
    write_active(data);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < count; i++) job_q.push_back(make_job(acq_pct));
    if (long_hold) begin
      @(negedge clk_i);
      hold_len = 300;
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_DEV; i++) job_load[i] = '0;
    active_cfg = lldp_pkg::ACTIVE_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset state: all counts zero, all sixteen devices active
    push_job(lldp_pkg::OP_ACQUIRE, DEV_W'($urandom_range(0, 15)));
    push_job(lldp_pkg::OP_ACQUIRE, 4'd15);
    push_job(lldp_pkg::OP_ACQUIRE, 4'd0);
    push_job(lldp_pkg::OP_RELEASE, 4'd1);
    push_job(lldp_pkg::OP_RELEASE, 4'd1);   // idle device
    push_job(lldp_pkg::OP_RELEASE, 4'd15);  // idle device at top index
    push_job(lldp_pkg::OP_ACQUIRE, DEV_W'($urandom_range(0, 15)));  // tie, lowest index
    push_job(lldp_pkg::OP_RELEASE, 4'd0);
    wait_idle();

    // zero acts as a single device
    write_active('0);
    push_job(lldp_pkg::OP_ACQUIRE, 4'd7);
    push_job(lldp_pkg::OP_RELEASE, 4'd1);   // out of range
    push_job(lldp_pkg::OP_RELEASE, 4'd15);  // out of range
    push_job(lldp_pkg::OP_RELEASE, 4'd0);
    push_job(lldp_pkg::OP_RELEASE, 4'd0);   // idle device
    wait_idle();

    // above sixteen clamps to the full table, counts survive the writes
    write_active(32'hFFFF_FFFF);
    push_job(lldp_pkg::OP_ACQUIRE, 4'd3);
    push_job(lldp_pkg::OP_ACQUIRE, 4'd9);
    push_job(lldp_pkg::OP_RELEASE, 4'd15);
    push_job(lldp_pkg::OP_RELEASE, 4'd3);
    push_job(lldp_pkg::OP_RELEASE, 4'd2);

    run_phase(5'd16, 95, 55, 20, 20, 1'b0);
    run_phase(5'd1, 90, 50, 15, 25, 1'b1);
    run_phase(ACTIVE_W'($urandom_range(2, 15)), 95, 60, 0, 0, 1'b0);
    run_phase(5'd31, 95, 40, 25, 10, 1'b0);
    run_phase(5'd0, 90, 45, 10, 30, 1'b0);
    run_phase(ACTIVE_W'($urandom_range(2, 8)), 95, 50, 20, 20, 1'b0);
    run_phase(5'd16, 90, 55, 0, 0, 1'b0);

    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (pick_q.size() != 0) flag_error("results still outstanding at end");
    if (errors == 0) begin
      $display("PASS least_loaded_device_picker_top");
    end else begin
      $display("FAIL least_loaded_device_picker_top");
    end
    $finish;
  end

endmodule
